// ===== design/rtnv_pkg.sv =====
// ----------------------------------------------------------------------------
// rtnv_pkg: shared types and constants of the RGB to NV12 block converter
// Pixel unpacking, BT.709 coefficients, constant divisors with their
// reciprocals, and the pipeline depths used by the chroma merge and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rtnv_pkg;

  // Port and code widths
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned QUO_W     = 9;
  localparam int unsigned RECIP_W   = 32;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_ORDER    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMITED = 1'b1;

  // Configuration as seen by the lanes
  typedef struct packed {
    logic chan_order;
    logic range_limited;
  } cfg_t;

  // One unpacked pixel
  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  // Rounded chroma quotient and its sign
  typedef struct packed {
    logic             neg;
    logic [QUO_W-1:0] q;
  } chroma_res_t;

  // Luma: w = 2126 R + 7152 G + 722 B, n = scale * w, divided by 2550000
  localparam int unsigned LUMA_W_W        = 22;
  localparam int unsigned LUMA_N_W        = 30;
  localparam int unsigned LUMA_KR         = 2126;
  localparam int unsigned LUMA_KG         = 7152;
  localparam int unsigned LUMA_KB         = 722;
  localparam int unsigned LUMA_SCALE_LTD  = 219;
  localparam int unsigned LUMA_SCALE_FULL = 255;
  localparam int unsigned LUMA_OFF_LTD    = 16;
  localparam longint unsigned LUMA_DIV    = 64'd2550000;
  localparam int unsigned LUMA_DIV_W      = 22;
  localparam int unsigned LUMA_PRE        = 0;
  localparam int unsigned LUMA_K          = 53;
  localparam longint unsigned LUMA_RECIP  = (64'd1 << LUMA_K) / LUMA_DIV;

  // Chroma: channel sums, signed weighted sum, scale, divided by 1020000000
  localparam int unsigned SUM_W = 10;
  localparam int unsigned C_W   = 31;
  localparam int unsigned CP_W  = 38;
  localparam int unsigned CM_W  = 37;
  localparam logic signed [C_W-1:0] CB_KR = C_W'(-114572);
  localparam logic signed [C_W-1:0] CB_KG = C_W'(-385428);
  localparam logic signed [C_W-1:0] CB_KB = C_W'(500000);
  localparam logic signed [C_W-1:0] CR_KR = C_W'(500000);
  localparam logic signed [C_W-1:0] CR_KG = C_W'(-454153);
  localparam logic signed [C_W-1:0] CR_KB = C_W'(-45847);
  localparam int unsigned CHR_SCALE_LTD  = 224;
  localparam int unsigned CHR_SCALE_FULL = 255;
  localparam int unsigned CHR_CENTER     = 128;
  localparam longint unsigned CHR_DIV    = 64'd1020000000;
  localparam int unsigned CHR_DIV_W      = 30;
  localparam int unsigned CHR_PRE        = 8;
  localparam int unsigned CHR_K          = 61;
  localparam longint unsigned CHR_RECIP  = (64'd1 << CHR_K) / CHR_DIV;

  // Pipeline depths
  localparam int unsigned DIV_LAT   = 5;
  localparam int unsigned FRONT_LAT = 4;
  localparam int unsigned PIPE_LAT  = FRONT_LAT + DIV_LAT + 1;

  localparam int unsigned CODE_MAX = 255;

  // Split a packed pixel word; alpha in bits 31:24 is dropped
  function automatic rgb_t unpack_pixel(logic [PIX_W-1:0] word, logic order);
    rgb_t px;
    px.g = word[15:8];
    if (order) begin
      px.r = word[23:16];
      px.b = word[7:0];
    end else begin
      px.r = word[7:0];
      px.b = word[23:16];
    end
    return px;
  endfunction

endpackage

`default_nettype wire

// ===== design/rtnv_cdiv.sv =====
// ----------------------------------------------------------------------------
// rtnv_cdiv: pipelined division by a constant, round half to even
// Reciprocal multiply gives a quotient at most one low, a remainder step
// fixes it, and the last stage rounds. Five stages, one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rtnv_cdiv #(
  parameter int unsigned     NUM_W       = rtnv_pkg::LUMA_N_W,
  parameter int unsigned     DIV_W       = rtnv_pkg::LUMA_DIV_W,
  parameter longint unsigned DIVISOR     = rtnv_pkg::LUMA_DIV,
  parameter longint unsigned RECIP       = rtnv_pkg::LUMA_RECIP,
  parameter int unsigned     PRE_SHIFT   = rtnv_pkg::LUMA_PRE,
  parameter int unsigned     RECIP_SHIFT = rtnv_pkg::LUMA_K
) (
  input  wire logic                        clk,
  input  wire logic [NUM_W-1:0]            num,
  output      logic [rtnv_pkg::QUO_W-1:0]  quo
);

  localparam int unsigned QW    = rtnv_pkg::QUO_W;
  localparam int unsigned RW    = rtnv_pkg::RECIP_W;
  localparam int unsigned HI_W  = NUM_W - PRE_SHIFT;
  localparam int unsigned PR_W  = HI_W + RW;
  localparam int unsigned QD_W  = QW + DIV_W;
  localparam logic [DIV_W-1:0] DivConst   = DIV_W'(DIVISOR);
  localparam logic [RW-1:0]    RecipConst = RW'(RECIP);

  // stage 1: quotient estimate
  logic [HI_W-1:0]  num_hi;
  logic [PR_W-1:0]  prod;
  logic [QW-1:0]    q0_nxt;
  logic [QW-1:0]    q0_r;
  logic [NUM_W-1:0] n1_r;

  assign num_hi = num[NUM_W-1:PRE_SHIFT];
  assign prod   = PR_W'(num_hi) * PR_W'(RecipConst);
  assign q0_nxt = QW'(prod >> (RECIP_SHIFT - PRE_SHIFT));

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    n1_r <= num;
  end

  // stage 2: quotient times divisor
  logic [QD_W-1:0]  qd_full;
  logic [NUM_W-1:0] qd_r;
  logic [QW-1:0]    q1_r;
  logic [NUM_W-1:0] n2_r;

  assign qd_full = QD_W'(q0_r) * QD_W'(DivConst);

  always_ff @(posedge clk) begin
    qd_r <= NUM_W'(qd_full);
    q1_r <= q0_r;
    n2_r <= n1_r;
  end

  // stage 3: remainder, below twice the divisor
  logic [NUM_W-1:0] diff;
  logic [DIV_W:0]   r0_r;
  logic [QW-1:0]    q2_r;

  assign diff = n2_r - qd_r;

  always_ff @(posedge clk) begin
    r0_r <= (DIV_W+1)'(diff);
    q2_r <= q1_r;
  end

  // stage 4: one correction step
  logic [DIV_W:0]   r0_sub;
  logic [DIV_W-1:0] r3_nxt;
  logic [QW-1:0]    q3_nxt;
  logic [DIV_W-1:0] r3_r;
  logic [QW-1:0]    q3_r;

  assign r0_sub = r0_r - {1'b0, DivConst};

  always_comb begin
    if (r0_r >= {1'b0, DivConst}) begin
      r3_nxt = r0_sub[DIV_W-1:0];
      q3_nxt = q2_r + QW'(1);
    end else begin
      r3_nxt = r0_r[DIV_W-1:0];
      q3_nxt = q2_r;
    end
  end

  always_ff @(posedge clk) begin
    r3_r <= r3_nxt;
    q3_r <= q3_nxt;
  end

  // stage 5: round to nearest, ties to even
  logic [DIV_W:0] twice_r;
  logic           round_up;
  logic [QW-1:0]  quo_r;

  assign twice_r  = {r3_r, 1'b0};
  assign round_up = (twice_r > {1'b0, DivConst}) ||
                    ((twice_r == {1'b0, DivConst}) && q3_r[0]);

  always_ff @(posedge clk) begin
    quo_r <= q3_r + QW'(round_up);
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

// ===== design/rtnv_luma_lane.sv =====
// ----------------------------------------------------------------------------
// rtnv_luma_lane: luma path of one pixel
// Weighted sum, range scale, alignment with the chroma path, then the
// constant divider. Gives the rounded luma quotient before offset and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module rtnv_luma_lane (
  input  wire logic                        clk,
  input  wire rtnv_pkg::cfg_t              cfg,
  input  wire rtnv_pkg::rgb_t              pix,
  output      logic [rtnv_pkg::QUO_W-1:0]  luma_q
);

  localparam int unsigned WW = rtnv_pkg::LUMA_W_W;
  localparam int unsigned NW = rtnv_pkg::LUMA_N_W;

  // stage 1: weighted channel sum
  logic [WW-1:0] w_nxt;
  logic [WW-1:0] w_r;

  assign w_nxt = WW'(pix.r) * WW'(rtnv_pkg::LUMA_KR) +
                 WW'(pix.g) * WW'(rtnv_pkg::LUMA_KG) +
                 WW'(pix.b) * WW'(rtnv_pkg::LUMA_KB);

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
  end

  // stage 2: range scale
  logic [rtnv_pkg::CH_W-1:0] scale;
  logic [NW-1:0]             n_nxt;
  logic [NW-1:0]             n_r;

  assign scale = cfg.range_limited ? rtnv_pkg::CH_W'(rtnv_pkg::LUMA_SCALE_LTD)
                                   : rtnv_pkg::CH_W'(rtnv_pkg::LUMA_SCALE_FULL);
  assign n_nxt = NW'(w_r) * NW'(scale);

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
  end

  // stages 3-4: line up with the chroma front end
  logic [NW-1:0] nd1_r;
  logic [NW-1:0] nd2_r;

  always_ff @(posedge clk) begin
    nd1_r <= n_r;
    nd2_r <= nd1_r;
  end

  rtnv_cdiv #(
    .NUM_W       (NW),
    .DIV_W       (rtnv_pkg::LUMA_DIV_W),
    .DIVISOR     (rtnv_pkg::LUMA_DIV),
    .RECIP       (rtnv_pkg::LUMA_RECIP),
    .PRE_SHIFT   (rtnv_pkg::LUMA_PRE),
    .RECIP_SHIFT (rtnv_pkg::LUMA_K)
  ) u_div (
    .clk (clk),
    .num (nd2_r),
    .quo (luma_q)
  );

endmodule

`default_nettype wire

// ===== design/rtnv_chroma_merge.sv =====
// ----------------------------------------------------------------------------
// rtnv_chroma_merge: merges the four pixels into one Cb/Cr pair
// Channel sums, signed weighted sums, range scale, magnitude and sign,
// then one constant divider per component.
// ----------------------------------------------------------------------------
`default_nettype none

module rtnv_chroma_merge (
  input  wire logic                  clk,
  input  wire rtnv_pkg::cfg_t        cfg,
  input  wire rtnv_pkg::rgb_t        pix [4],
  output      rtnv_pkg::chroma_res_t chroma [2]
);

  localparam int unsigned SW = rtnv_pkg::SUM_W;
  localparam int unsigned CW = rtnv_pkg::C_W;
  localparam int unsigned PW = rtnv_pkg::CP_W;
  localparam int unsigned MW = rtnv_pkg::CM_W;
  localparam int unsigned DL = rtnv_pkg::DIV_LAT;

  // stage 1: per channel sums over the block
  logic [SW-1:0] sr_nxt, sg_nxt, sb_nxt;
  logic [SW-1:0] sr_r, sg_r, sb_r;

  assign sr_nxt = SW'(pix[0].r) + SW'(pix[1].r) + SW'(pix[2].r) + SW'(pix[3].r);
  assign sg_nxt = SW'(pix[0].g) + SW'(pix[1].g) + SW'(pix[2].g) + SW'(pix[3].g);
  assign sb_nxt = SW'(pix[0].b) + SW'(pix[1].b) + SW'(pix[2].b) + SW'(pix[3].b);

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
    sg_r <= sg_nxt;
    sb_r <= sb_nxt;
  end

  // stage 2: signed color difference sums (index 0 is Cb, 1 is Cr)
  logic signed [CW-1:0] sr_s, sg_s, sb_s;
  logic signed [CW-1:0] c_nxt [2];
  logic signed [CW-1:0] c_r   [2];

  assign sr_s = $signed(CW'(sr_r));
  assign sg_s = $signed(CW'(sg_r));
  assign sb_s = $signed(CW'(sb_r));

  assign c_nxt[0] = rtnv_pkg::CB_KR * sr_s + rtnv_pkg::CB_KG * sg_s +
                    rtnv_pkg::CB_KB * sb_s;
  assign c_nxt[1] = rtnv_pkg::CR_KR * sr_s + rtnv_pkg::CR_KG * sg_s +
                    rtnv_pkg::CR_KB * sb_s;

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
  end

  // stage 3: range scale
  logic signed [PW-1:0] scale;

  assign scale = cfg.range_limited ? $signed(PW'(rtnv_pkg::CHR_SCALE_LTD))
                                   : $signed(PW'(rtnv_pkg::CHR_SCALE_FULL));

  // per component: scale, magnitude, divider, sign delay
  for (genvar i = 0; i < 2; i++) begin : g_comp
    logic signed [PW-1:0] sp_nxt;
    logic signed [PW-1:0] sp_r;
    logic [PW-1:0]        sp_abs;
    logic [MW-1:0]        mag_r;
    logic                 neg_r;
    logic [DL-1:0]        neg_pipe_r;
    logic [rtnv_pkg::QUO_W-1:0] quo;

    assign sp_nxt = PW'(c_r[i]) * scale;

    always_ff @(posedge clk) begin
      sp_r <= sp_nxt;
    end

    // stage 4: sign and magnitude
    assign sp_abs = sp_r[PW-1] ? PW'(-sp_r) : PW'(sp_r);

    always_ff @(posedge clk) begin
      mag_r      <= MW'(sp_abs);
      neg_r      <= sp_r[PW-1];
      neg_pipe_r <= {neg_pipe_r[DL-2:0], neg_r};
    end

    rtnv_cdiv #(
      .NUM_W       (MW),
      .DIV_W       (rtnv_pkg::CHR_DIV_W),
      .DIVISOR     (rtnv_pkg::CHR_DIV),
      .RECIP       (rtnv_pkg::CHR_RECIP),
      .PRE_SHIFT   (rtnv_pkg::CHR_PRE),
      .RECIP_SHIFT (rtnv_pkg::CHR_K)
    ) u_div (
      .clk (clk),
      .num (mag_r),
      .quo (quo)
    );

    assign chroma[i].q   = quo;
    assign chroma[i].neg = neg_pipe_r[DL-1];
  end

endmodule

`default_nettype wire

// ===== design/rgb_to_nv12_block_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_nv12_block_converter: BT.709 RGB 2x2 block to 4:2:0 YCbCr codes
// Four luma lanes and a chroma merge stage, all fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one 2x2 pixel item in every clock cycle: busy stays low, so
// an item is accepted whenever start is high. Each result is shown for one
// cycle, marked by out_valid, in the order the items came in; the receiver
// must take every result when it is shown. The item passes through ten
// pipeline registers: the four front stages (weighting, scaling, sign
// handling), the five-stage constant divider (reciprocal multiply, remainder,
// correction, rounding) and the output register. Configuration writes are
// always ready and should be made only while no items are in flight.
`default_nettype none

module rgb_to_nv12_block_converter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // item input
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic [rtnv_pkg::PIX_W-1:0]       in_pixel_top_left,
  input  wire logic [rtnv_pkg::PIX_W-1:0]       in_pixel_top_right,
  input  wire logic [rtnv_pkg::PIX_W-1:0]       in_pixel_bottom_left,
  input  wire logic [rtnv_pkg::PIX_W-1:0]       in_pixel_bottom_right,
  // results
  output      logic                             out_valid,
  output      logic [rtnv_pkg::CODE_W-1:0]      out_luma_top_left,
  output      logic [rtnv_pkg::CODE_W-1:0]      out_luma_top_right,
  output      logic [rtnv_pkg::CODE_W-1:0]      out_luma_bottom_left,
  output      logic [rtnv_pkg::CODE_W-1:0]      out_luma_bottom_right,
  output      logic [rtnv_pkg::CODE_W-1:0]      out_cb_code,
  output      logic [rtnv_pkg::CODE_W-1:0]      out_cr_code,
  // configuration writes
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [rtnv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic                             cfg_data
);

  localparam int unsigned QW = rtnv_pkg::QUO_W;
  localparam int unsigned LT = rtnv_pkg::PIPE_LAT;
  localparam int unsigned YW = QW + 1;
  localparam int unsigned KW = QW + 2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  rtnv_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtnv_pkg::REG_CHAN_ORDER:    cfg_r.chan_order    <= cfg_data;
        rtnv_pkg::REG_RANGE_LIMITED: cfg_r.range_limited <= cfg_data;
        default: ;
      endcase
    end
  end

  // item valid pipeline
  logic          accept;
  logic [LT-1:0] vld_nxt;
  logic [LT-1:0] vld_r;

  assign accept  = start && !busy;
  assign vld_nxt = {vld_r[LT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // unpack the four pixels
  rtnv_pkg::rgb_t pix [4];

  assign pix[0] = rtnv_pkg::unpack_pixel(in_pixel_top_left,     cfg_r.chan_order);
  assign pix[1] = rtnv_pkg::unpack_pixel(in_pixel_top_right,    cfg_r.chan_order);
  assign pix[2] = rtnv_pkg::unpack_pixel(in_pixel_bottom_left,  cfg_r.chan_order);
  assign pix[3] = rtnv_pkg::unpack_pixel(in_pixel_bottom_right, cfg_r.chan_order);

  // luma lanes
  logic [QW-1:0] luma_q [4];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    rtnv_luma_lane u_lane (
      .clk    (clk),
      .cfg    (cfg_r),
      .pix    (pix[i]),
      .luma_q (luma_q[i])
    );
  end

  // chroma merge
  rtnv_pkg::chroma_res_t chroma [2];

  rtnv_chroma_merge u_merge (
    .clk    (clk),
    .cfg    (cfg_r),
    .pix    (pix),
    .chroma (chroma)
  );

  // output stage: offset and clamp
  logic [YW-1:0]             luma_off;
  logic [YW-1:0]             y_sum  [4];
  logic [rtnv_pkg::CODE_W-1:0] y_nxt [4];
  logic [rtnv_pkg::CODE_W-1:0] y_r   [4];
  logic signed [KW-1:0]      k_sum  [2];
  logic [rtnv_pkg::CODE_W-1:0] k_nxt [2];
  logic [rtnv_pkg::CODE_W-1:0] k_r   [2];

  assign luma_off = cfg_r.range_limited ? YW'(rtnv_pkg::LUMA_OFF_LTD) : '0;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      y_sum[i] = YW'(luma_q[i]) + luma_off;
      if (y_sum[i] > YW'(rtnv_pkg::CODE_MAX)) begin
        y_nxt[i] = rtnv_pkg::CODE_W'(rtnv_pkg::CODE_MAX);
      end else begin
        y_nxt[i] = y_sum[i][rtnv_pkg::CODE_W-1:0];
      end
    end
    for (int j = 0; j < 2; j++) begin
      if (chroma[j].neg) begin
        k_sum[j] = $signed(KW'(rtnv_pkg::CHR_CENTER)) - $signed(KW'(chroma[j].q));
      end else begin
        k_sum[j] = $signed(KW'(rtnv_pkg::CHR_CENTER)) + $signed(KW'(chroma[j].q));
      end
      if (k_sum[j] < 0) begin
        k_nxt[j] = '0;
      end else if (k_sum[j] > $signed(KW'(rtnv_pkg::CODE_MAX))) begin
        k_nxt[j] = rtnv_pkg::CODE_W'(rtnv_pkg::CODE_MAX);
      end else begin
        k_nxt[j] = k_sum[j][rtnv_pkg::CODE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
    k_r <= k_nxt;
  end

  assign out_valid             = vld_r[LT-1];
  assign out_luma_top_left     = y_r[0];
  assign out_luma_top_right    = y_r[1];
  assign out_luma_bottom_left  = y_r[2];
  assign out_luma_bottom_right = y_r[3];
  assign out_cb_code           = k_r[0];
  assign out_cr_code           = k_r[1];

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RGB to NV12 block converter
// Drives 2x2 pixel items through the converter under every register setting,
// predicts the four luma codes and the Cb/Cr pair of each item, and compares
// every result against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_top;

  // Bench constants
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 17;
  localparam int RAND_ITEMS  = 100;
  localparam int MAX_REPORTS = 10;

  // Chroma weights, signed, at full width
  localparam longint CB_WR = -114572;
  localparam longint CB_WG = -385428;
  localparam longint CB_WB = 500000;
  localparam longint CR_WR = 500000;
  localparam longint CR_WG = -454153;
  localparam longint CR_WB = -45847;

  // Codes of one 2x2 item
  typedef struct packed {
    logic [rtnv_pkg::CODE_W-1:0] y_tl;
    logic [rtnv_pkg::CODE_W-1:0] y_tr;
    logic [rtnv_pkg::CODE_W-1:0] y_bl;
    logic [rtnv_pkg::CODE_W-1:0] y_br;
    logic [rtnv_pkg::CODE_W-1:0] cb;
    logic [rtnv_pkg::CODE_W-1:0] cr;
  } nv12_codes_t;

  logic                           clk   = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [rtnv_pkg::PIX_W-1:0]     in_pixel_top_left     = '0;
  logic [rtnv_pkg::PIX_W-1:0]     in_pixel_top_right    = '0;
  logic [rtnv_pkg::PIX_W-1:0]     in_pixel_bottom_left  = '0;
  logic [rtnv_pkg::PIX_W-1:0]     in_pixel_bottom_right = '0;
  logic                           out_valid;
  logic [rtnv_pkg::CODE_W-1:0]    out_luma_top_left;
  logic [rtnv_pkg::CODE_W-1:0]    out_luma_top_right;
  logic [rtnv_pkg::CODE_W-1:0]    out_luma_bottom_left;
  logic [rtnv_pkg::CODE_W-1:0]    out_luma_bottom_right;
  logic [rtnv_pkg::CODE_W-1:0]    out_cb_code;
  logic [rtnv_pkg::CODE_W-1:0]    out_cr_code;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rtnv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic                           cfg_data  = 1'b0;

  // Bench copy of the registers and the store of predicted codes
  logic        chan_order_q    = 1'b0;
  logic        range_limited_q = 1'b0;
  nv12_codes_t expected_codes[$];

  int  mismatch_count = 0;
  int  fail_count     = 0;
  int  stall_cycles   = 0;
  bit  idle_enable    = 1'b1;

  rgb_to_nv12_block_converter dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_pixel_top_left     (in_pixel_top_left),
    .in_pixel_top_right    (in_pixel_top_right),
    .in_pixel_bottom_left  (in_pixel_bottom_left),
    .in_pixel_bottom_right (in_pixel_bottom_right),
    .out_valid             (out_valid),
    .out_luma_top_left     (out_luma_top_left),
    .out_luma_top_right    (out_luma_top_right),
    .out_luma_bottom_left  (out_luma_bottom_left),
    .out_luma_bottom_right (out_luma_bottom_right),
    .out_cb_code           (out_cb_code),
    .out_cr_code           (out_cr_code),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Code prediction
  // ---------------------------------------------------------------------------

  // Unsigned divide, round to nearest, ties to even
  function automatic longint unsigned div_half_even(longint unsigned mag,
                                                    longint unsigned dv);
    longint unsigned q;
    longint unsigned r;
    q = mag / dv;
    r = mag % dv;
    if ((2 * r > dv) || ((2 * r == dv) && q[0]))
      q = q + 1;
    return q;
  endfunction

  // Same rounding, symmetric in sign
  function automatic longint sdiv_half_even(longint num, longint unsigned dv);
    longint unsigned mag;
    longint          q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q   = longint'(div_half_even(mag, dv));
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [rtnv_pkg::CODE_W-1:0] sat_code(longint v);
    if (v < 0)
      return '0;
    if (v > rtnv_pkg::CODE_MAX)
      return rtnv_pkg::CODE_W'(rtnv_pkg::CODE_MAX);
    return rtnv_pkg::CODE_W'(v);
  endfunction

  // Byte order of a word under the current channel order
  function automatic rtnv_pkg::rgb_t split_word(logic [rtnv_pkg::PIX_W-1:0] word,
                                                logic bgra);
    rtnv_pkg::rgb_t px;
    px.g = word[15:8];
    px.r = bgra ? word[23:16] : word[7:0];
    px.b = bgra ? word[7:0] : word[23:16];
    return px;
  endfunction

  function automatic logic [rtnv_pkg::CODE_W-1:0] luma_of(rtnv_pkg::rgb_t px,
                                                          logic limited);
    longint unsigned scale;
    longint unsigned w;
    longint          off;
    scale = limited ? rtnv_pkg::LUMA_SCALE_LTD : rtnv_pkg::LUMA_SCALE_FULL;
    off   = limited ? rtnv_pkg::LUMA_OFF_LTD : 0;
    w     = rtnv_pkg::LUMA_KR * longint'(px.r) + rtnv_pkg::LUMA_KG * longint'(px.g)
          + rtnv_pkg::LUMA_KB * longint'(px.b);
    return sat_code(off + longint'(div_half_even(scale * w, rtnv_pkg::LUMA_DIV)));
  endfunction

  function automatic logic [rtnv_pkg::CODE_W-1:0] chroma_of(longint c, logic limited);
    longint scale;
    scale = limited ? rtnv_pkg::CHR_SCALE_LTD : rtnv_pkg::CHR_SCALE_FULL;
    return sat_code(rtnv_pkg::CHR_CENTER + sdiv_half_even(scale * c, rtnv_pkg::CHR_DIV));
  endfunction

  function automatic nv12_codes_t predict_codes(logic [rtnv_pkg::PIX_W-1:0] tl,
                                                logic [rtnv_pkg::PIX_W-1:0] tr,
                                                logic [rtnv_pkg::PIX_W-1:0] bl,
                                                logic [rtnv_pkg::PIX_W-1:0] br,
                                                logic bgra, logic limited);
    rtnv_pkg::rgb_t px[4];
    longint         sr;
    longint         sg;
    longint         sb;
    nv12_codes_t    codes;
    px[0] = split_word(tl, bgra);
    px[1] = split_word(tr, bgra);
    px[2] = split_word(bl, bgra);
    px[3] = split_word(br, bgra);
    sr = 0;
    sg = 0;
    sb = 0;
    for (int i = 0; i < 4; i++) begin
      sr += px[i].r;
      sg += px[i].g;
      sb += px[i].b;
    end
    codes.y_tl = luma_of(px[0], limited);
    codes.y_tr = luma_of(px[1], limited);
    codes.y_bl = luma_of(px[2], limited);
    codes.y_br = luma_of(px[3], limited);
    codes.cb   = chroma_of(CB_WR * sr + CB_WG * sg + CB_WB * sb, limited);
    codes.cr   = chroma_of(CR_WR * sr + CR_WG * sg + CR_WB * sb, limited);
    return codes;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, register tracking and item prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    nv12_codes_t got;
    nv12_codes_t want;
    if (!rst_n) begin
      chan_order_q    <= 1'b0;
      range_limited_q <= 1'b0;
    end else begin
      // compare the result shown in the cycle that just ended
      if (out_valid) begin
        got = {out_luma_top_left, out_luma_top_right, out_luma_bottom_left,
               out_luma_bottom_right, out_cb_code, out_cr_code};
        if (expected_codes.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] unexpected result: y %0d %0d %0d %0d cb %0d cr %0d",
                     $realtime, got.y_tl, got.y_tr, got.y_bl, got.y_br,
                     got.cb, got.cr);
        end else begin
          want = expected_codes.pop_front();
          if (got !== want) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("[%0t] mismatch: exp y %0d %0d %0d %0d cb %0d cr %0d",
                       $realtime, want.y_tl, want.y_tr, want.y_bl, want.y_br,
                       want.cb, want.cr);
              $display("[%0t]           got y %0d %0d %0d %0d cb %0d cr %0d",
                       $realtime, got.y_tl, got.y_tr, got.y_bl, got.y_br,
                       got.cb, got.cr);
            end
          end
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rtnv_pkg::REG_CHAN_ORDER:    chan_order_q    <= cfg_data;
          rtnv_pkg::REG_RANGE_LIMITED: range_limited_q <= cfg_data;
          default: ;
        endcase
      end
      // accepted item
      if (start && !busy)
        expected_codes.push_back(predict_codes(in_pixel_top_left, in_pixel_top_right,
                                               in_pixel_bottom_left,
                                               in_pixel_bottom_right,
                                               chan_order_q, range_limited_q));
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------------

  // Send one item; returns at the falling edge after it was accepted
  task automatic drive_block(input logic [rtnv_pkg::PIX_W-1:0] tl,
                             input logic [rtnv_pkg::PIX_W-1:0] tr,
                             input logic [rtnv_pkg::PIX_W-1:0] bl,
                             input logic [rtnv_pkg::PIX_W-1:0] br);
    while (idle_enable && ($urandom_range(99) < IDLE_PCT)) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start                 <= 1'b1;
    in_pixel_top_left     <= tl;
    in_pixel_top_right    <= tr;
    in_pixel_bottom_left  <= bl;
    in_pixel_bottom_right <= br;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending, let every result come back, then let the pipe empty
  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_codes.size() != 0)
      @(negedge clk);
    repeat (rtnv_pkg::PIPE_LAT + 2)
      @(negedge clk);
  endtask

  task automatic write_register(input logic [rtnv_pkg::CFG_IDX_W-1:0] idx,
                                input logic value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random pixel word, weighted toward extremes and near-gray content
  function automatic logic [rtnv_pkg::PIX_W-1:0] random_pixel();
    logic [rtnv_pkg::PIX_W-1:0] word;
    logic [7:0]                 base;
    word = $urandom;
    case ($urandom_range(5))
      0: begin
        // each color byte either 00 or FF
        for (int i = 0; i < 3; i++)
          word[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      1: begin
        // near gray
        base = $urandom;
        for (int i = 0; i < 3; i++)
          word[8*i +: 8] = base + 8'($urandom_range(4)) - 8'd2;
      end
      2: begin
        // one saturated channel
        word[23:0] = 24'hFF << (8 * $urandom_range(2));
      end
      default: ;
    endcase
    return word;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: RGBA order, full range; extremes and chroma clamping
  task automatic test_reset_defaults();
    drive_block(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    drive_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // pure blue: Cb lands on 256 and clamps
    drive_block(32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000);
    // pure red: Cr lands on 256 and clamps
    drive_block(32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF);
    // yellow and cyan drive chroma to the low side
    drive_block(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    drive_block(32'h00FF_FF00, 32'h00FF_FF00, 32'h00FF_FF00, 32'h00FF_FF00);
    // alpha only: must read as black
    drive_block(32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000);
    drive_block(32'h00FF_FFFF, 32'h0000_0000, 32'h5A00_0000, 32'hA5FF_FFFF);
    wait_for_results();
  endtask

  // BGRA order in full range
  task automatic test_chan_order();
    write_register(rtnv_pkg::REG_CHAN_ORDER, 1'b1);
    write_register(rtnv_pkg::REG_RANGE_LIMITED, 1'b0);
    drive_block(32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF);
    drive_block(32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000);
    drive_block(32'h1234_5678, 32'h8765_4321, 32'h00FF_00FF, 32'hFF00_FF00);
    wait_for_results();
  endtask

  // Limited range under both orders
  task automatic test_limited_range();
    write_register(rtnv_pkg::REG_RANGE_LIMITED, 1'b1);
    drive_block(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    drive_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_block(32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF);
    drive_block(32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000);
    drive_block(32'h0080_8080, 32'h0080_8080, 32'h0080_8080, 32'h0080_8080);
    wait_for_results();
    write_register(rtnv_pkg::REG_CHAN_ORDER, 1'b0);
    drive_block(32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF);
    drive_block(32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000, 32'h00FF_0000);
    drive_block(32'h0010_EB80, 32'h00EB_1080, 32'h8080_10EB, 32'h0001_0203);
    wait_for_results();
  endtask

  // Random items under each setting; one phase runs with no idling
  task automatic test_random_blocks();
    logic [1:0] setting;
    for (int phase = 0; phase < 4; phase++) begin
      setting     = 2'(phase);
      idle_enable = (phase != 1);
      write_register(rtnv_pkg::REG_CHAN_ORDER, setting[0]);
      write_register(rtnv_pkg::REG_RANGE_LIMITED, setting[1]);
      for (int n = 0; n < RAND_ITEMS; n++)
        drive_block(random_pixel(), random_pixel(), random_pixel(), random_pixel());
      wait_for_results();
    end
    idle_enable = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6)
      @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_chan_order();
    test_limited_range();
    test_random_blocks();

    wait_for_results();
    fail_count += expected_codes.size();
    if (fail_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
